// ----- rtl/multi_byte_stuffing_framer_top_assert.svh -----
// assertion macros for the multi-byte stuffing framer
`ifndef MULTI_BYTE_STUFFING_FRAMER_TOP_ASSERT_SVH
`define MULTI_BYTE_STUFFING_FRAMER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MBSF_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define MBSF_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/mbsf_pkg.sv -----
// shared types, constants and helpers of the multi-byte stuffing framer
package mbsf_pkg;

	// window cells: lookahead bytes plus the incoming byte
	localparam int MAX_PAT   = 4;
	localparam int STUFF_MAX = 4;
	localparam int ESC_LEN   = 3;

	localparam logic [2:0] PAT_LIM   = 3'(MAX_PAT);
	localparam logic [2:0] STUFF_LIM = 3'(STUFF_MAX);

	// escape sequence, first byte in lowest slot
	localparam logic [ESC_LEN-1:0][7:0] ESC_SEQ = {8'h63, 8'h73, 8'h65};

	// command codes
	localparam logic [1:0] CMD_OPEN  = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_START_PAT = 3'd0;
	localparam logic [2:0] REG_START_LEN = 3'd1;
	localparam logic [2:0] REG_END_PAT   = 3'd2;
	localparam logic [2:0] REG_END_LEN   = 3'd3;
	localparam logic [2:0] REG_STUFF_PAT = 3'd4;
	localparam logic [2:0] REG_STUFF_LEN = 3'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} res_item_t;

	typedef struct packed {
		logic [31:0] start_pat;
		logic [2:0]  start_len;
		logic [31:0] end_pat;
		logic [2:0]  end_len;
		logic [31:0] stuff_pat;
		logic [2:0]  stuff_len;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       eq_start;
		logic       eq_end;
		logic       eq_esc;
	} cell_stat_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic clear;
	} win_ctrl_t;

	typedef struct packed {
		logic busy;
		logic take;
	} seq_stat_t;

	function automatic logic [2:0] clamp_len(input logic [2:0] len, input logic [2:0] lim);
		logic [2:0] r;
		r = len;
		if (len == 3'd0) begin
			r = 3'd1;
		end else if (len > lim) begin
			r = lim;
		end
		return r;
	endfunction

	function automatic logic [1:0] last_idx(input logic [2:0] len);
		logic [2:0] t;
		t = len - 3'd1;
		return t[1:0];
	endfunction

	function automatic logic [7:0] pick_byte(input logic [31:0] pat, input logic [1:0] idx);
		return pat[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- rtl/mbsf_cell.sv -----
// one window cell: holds a byte, shifts towards the head, compares locally
module mbsf_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbsf_pkg::win_ctrl_t    ctrl,
	input  logic                   prev_valid,
	input  logic                   nxt_valid,
	input  logic [7:0]             nxt_data,
	input  logic [7:0]             load_data,
	input  logic [7:0]             start_byte,
	input  logic [7:0]             end_byte,
	input  logic [7:0]             esc_byte,
	input  logic                   esc_used,
	output mbsf_pkg::cell_stat_t   stat
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       append;

	// append goes to the first empty cell only
	assign append = ctrl.load && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nxt_valid;
		end else if (append) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= nxt_data;
		end else if (append) begin
			data_q <= load_data;
		end
	end

	always_comb begin
		stat.valid    = valid_q;
		stat.data     = data_q;
		stat.eq_start = (data_q == start_byte);
		stat.eq_end   = (data_q == end_byte);
		stat.eq_esc   = esc_used && (data_q == esc_byte);
	end

endmodule

// ----- rtl/mbsf_seq.sv -----
// emit sequencer: takes items, steps through delimiter, stuff and data bytes
module mbsf_seq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mbsf_pkg::cfg_t                          cfg,
	input  logic                                    item_valid,
	input  mbsf_pkg::cmd_item_t                     item,
	input  mbsf_pkg::cell_stat_t [mbsf_pkg::MAX_PAT-1:0] win,
	output mbsf_pkg::win_ctrl_t                     ctrl,
	output mbsf_pkg::seq_stat_t                     stat,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output mbsf_pkg::res_item_t                     res_item
);

	typedef enum logic [1:0] {ST_IDLE, ST_START, ST_PUT, ST_END} state_t;

	state_t              state_q;
	logic                open_q;
	logic                close_q;
	logic [1:0]          idx_q;
	logic [1:0]          stuffs_q;
	logic                res_valid_q;
	mbsf_pkg::res_item_t res_item_q;

	logic [2:0] slen, elen, tlen;
	logic       take, slot_free, emit;
	logic       m_start, m_end, m_esc;
	logic [1:0] nmatch;
	logic       stuff_pend;
	logic [7:0] out_byte;
	logic       out_last;

	always_comb begin
		slen = mbsf_pkg::clamp_len(cfg.start_len, mbsf_pkg::PAT_LIM);
		elen = mbsf_pkg::clamp_len(cfg.end_len, mbsf_pkg::PAT_LIM);
		tlen = mbsf_pkg::clamp_len(cfg.stuff_len, mbsf_pkg::STUFF_LIM);
	end

	// pattern matches at the head cell, cells beyond the length do not count
	always_comb begin
		m_start = 1'b1;
		m_end   = 1'b1;
		m_esc   = 1'b1;
		for (int k = 0; k < mbsf_pkg::MAX_PAT; k++) begin
			if (3'(k) < slen) begin
				m_start = m_start && win[k].valid && win[k].eq_start;
			end
			if (3'(k) < elen) begin
				m_end = m_end && win[k].valid && win[k].eq_end;
			end
			if (k < mbsf_pkg::ESC_LEN) begin
				m_esc = m_esc && win[k].valid && win[k].eq_esc;
			end
		end
		nmatch     = {1'b0, m_start} + {1'b0, m_end} + {1'b0, m_esc};
		stuff_pend = stuffs_q < nmatch;
	end

	always_comb begin
		take       = (state_q == ST_IDLE) && item_valid;
		slot_free  = !res_valid_q || !res_stall;
		emit       = (state_q != ST_IDLE) && slot_free;
		ctrl.clear = take && (item.command == mbsf_pkg::CMD_OPEN) && !open_q;
		ctrl.load  = take && (item.command == mbsf_pkg::CMD_DATA) && open_q;
		ctrl.shift = emit && (state_q == ST_PUT) && !stuff_pend;
		stat.busy  = state_q != ST_IDLE;
		stat.take  = take;
	end

	always_comb begin
		case (state_q)
			ST_START: begin
				out_byte = mbsf_pkg::pick_byte(cfg.start_pat, idx_q);
				out_last = idx_q == mbsf_pkg::last_idx(slen);
			end
			ST_PUT: begin
				if (stuff_pend) begin
					out_byte = mbsf_pkg::pick_byte(cfg.stuff_pat, idx_q);
					out_last = 1'b0;
				end else begin
					out_byte = win[0].data;
					out_last = !close_q;
				end
			end
			ST_END: begin
				out_byte = mbsf_pkg::pick_byte(cfg.end_pat, idx_q);
				out_last = idx_q == mbsf_pkg::last_idx(elen);
			end
			default: begin
				out_byte = 8'h00;
				out_last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_q      <= 1'b0;
			close_q     <= 1'b0;
			idx_q       <= 2'd0;
			stuffs_q    <= 2'd0;
			res_valid_q <= 1'b0;
			res_item_q  <= '0;
		end else begin
			if (slot_free) begin
				res_valid_q <= emit;
			end
			if (emit) begin
				res_item_q.out_byte <= out_byte;
				res_item_q.last     <= out_last;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						idx_q    <= 2'd0;
						stuffs_q <= 2'd0;
						case (item.command)
							mbsf_pkg::CMD_OPEN: begin
								if (!open_q) begin
									open_q  <= 1'b1;
									state_q <= ST_START;
								end
							end
							mbsf_pkg::CMD_DATA: begin
								if (open_q && win[mbsf_pkg::MAX_PAT-2].valid) begin
									close_q <= 1'b0;
									state_q <= ST_PUT;
								end
							end
							mbsf_pkg::CMD_CLOSE: begin
								if (open_q) begin
									open_q  <= 1'b0;
									close_q <= 1'b1;
									state_q <= win[0].valid ? ST_PUT : ST_END;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_START: begin
					if (emit) begin
						if (out_last) begin
							idx_q   <= 2'd0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_PUT: begin
					if (emit) begin
						if (stuff_pend) begin
							if (idx_q == mbsf_pkg::last_idx(tlen)) begin
								idx_q    <= 2'd0;
								stuffs_q <= stuffs_q + 2'd1;
							end else begin
								idx_q <= idx_q + 2'd1;
							end
						end else begin
							idx_q    <= 2'd0;
							stuffs_q <= 2'd0;
							if (!close_q) begin
								state_q <= ST_IDLE;
							end else if (!win[1].valid) begin
								state_q <= ST_END;
							end
						end
					end
				end
				ST_END: begin
					if (emit) begin
						if (out_last) begin
							idx_q   <= 2'd0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

// ----- rtl/multi_byte_stuffing_framer_top.sv -----
// top level of the multi-byte stuffing framer: registers, item buffer, cell row
// the first result byte passes the item buffer, the sequencer state and the output register
// the sequencer takes an item only while idle and takes no new one until its result bytes are sent
// a data item sends at most the head byte of the window; each match there first adds a stuff pattern
// the single emit sequencer sends one output byte per cycle while the result channel is not stalled
// reset: arst_n clears the frame state, the window valid bits and both valid flags
`include "multi_byte_stuffing_framer_top_assert.svh"

module multi_byte_stuffing_framer_top (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  mbsf_pkg::cmd_item_t cmd_data,
	// result channel
	output logic                byte_valid,
	input  logic                byte_stall,
	output mbsf_pkg::res_item_t byte_data,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	mbsf_pkg::cfg_t       cfg_q;
	logic                 in_valid_q;
	mbsf_pkg::cmd_item_t  in_item_q;
	mbsf_pkg::win_ctrl_t  win_ctrl;
	mbsf_pkg::seq_stat_t  seq_stat;
	mbsf_pkg::cell_stat_t [mbsf_pkg::MAX_PAT-1:0] win;
	logic [mbsf_pkg::MAX_PAT-1:0] win_valid;
	logic [2:0]           reg_idx;
	logic                 reg_wr;

	// ---------------------------------------------------------------
	// register port: always ready, written in the access phase
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pat <= 32'h0000_0002;
			cfg_q.start_len <= 3'd1;
			cfg_q.end_pat   <= 32'h0000_0003;
			cfg_q.end_len   <= 3'd1;
			cfg_q.stuff_pat <= 32'h0000_0010;
			cfg_q.stuff_len <= 3'd1;
		end else if (reg_wr) begin
			case (reg_idx)
				mbsf_pkg::REG_START_PAT: cfg_q.start_pat <= pwdata;
				mbsf_pkg::REG_START_LEN: cfg_q.start_len <= pwdata[2:0];
				mbsf_pkg::REG_END_PAT:   cfg_q.end_pat   <= pwdata;
				mbsf_pkg::REG_END_LEN:   cfg_q.end_len   <= pwdata[2:0];
				mbsf_pkg::REG_STUFF_PAT: cfg_q.stuff_pat <= pwdata;
				mbsf_pkg::REG_STUFF_LEN: cfg_q.stuff_len <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mbsf_pkg::REG_START_PAT: prdata = cfg_q.start_pat;
			mbsf_pkg::REG_START_LEN: prdata = {29'd0, cfg_q.start_len};
			mbsf_pkg::REG_END_PAT:   prdata = cfg_q.end_pat;
			mbsf_pkg::REG_END_LEN:   prdata = {29'd0, cfg_q.end_len};
			mbsf_pkg::REG_STUFF_PAT: prdata = cfg_q.stuff_pat;
			mbsf_pkg::REG_STUFF_LEN: prdata = {29'd0, cfg_q.stuff_len};
			default:                 prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// item buffer: one item waits here while the sequencer is busy,
	// so the source is not held up by a result stall straight away
	// ---------------------------------------------------------------
	assign cmd_stall = in_valid_q && !seq_stat.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			in_valid_q <= 1'b1;
		end else if (seq_stat.take) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			in_item_q <= cmd_data;
		end
	end

	// ---------------------------------------------------------------
	// cell row: cell 0 is the head of the window, bytes append at the
	// first empty cell and move one cell towards the head per shift;
	// the last cell takes the incoming byte once the cells before it are full
	// ---------------------------------------------------------------
	for (genvar k = 0; k < mbsf_pkg::MAX_PAT; k++) begin : g_cell
		logic       prev_v;
		logic       nxt_v;
		logic [7:0] nxt_d;
		logic [7:0] esc_b;
		logic       esc_u;

		if (k == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = win[k-1].valid;
		end

		if (k == mbsf_pkg::MAX_PAT - 1) begin : g_tail
			assign nxt_v = 1'b0;
			assign nxt_d = 8'h00;
		end else begin : g_link
			assign nxt_v = win[k+1].valid;
			assign nxt_d = win[k+1].data;
		end

		// only the first three cells take part in the escape match
		if (k < mbsf_pkg::ESC_LEN) begin : g_esc
			assign esc_b = mbsf_pkg::ESC_SEQ[k];
			assign esc_u = 1'b1;
		end else begin : g_noesc
			assign esc_b = 8'h00;
			assign esc_u = 1'b0;
		end

		mbsf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (win_ctrl),
			.prev_valid (prev_v),
			.nxt_valid  (nxt_v),
			.nxt_data   (nxt_d),
			.load_data  (in_item_q.data_byte),
			.start_byte (cfg_q.start_pat[8*k +: 8]),
			.end_byte   (cfg_q.end_pat[8*k +: 8]),
			.esc_byte   (esc_b),
			.esc_used   (esc_u),
			.stat       (win[k])
		);

		assign win_valid[k] = win[k].valid;
	end

	// ---------------------------------------------------------------
	// sequencer with the output register
	// ---------------------------------------------------------------
	mbsf_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (in_valid_q),
		.item       (in_item_q),
		.win        (win),
		.ctrl       (win_ctrl),
		.stat       (seq_stat),
		.res_valid  (byte_valid),
		.res_stall  (byte_stall),
		.res_item   (byte_data)
	);

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	localparam logic [mbsf_pkg::MAX_PAT-1:0] WIN_ONE = mbsf_pkg::MAX_PAT'(1);

	// valid cells always form an unbroken run from the head
	`MBSF_ASSERT_NEVER(a_win_prefix, clk, arst_n, (win_valid & (win_valid + WIN_ONE)) != '0, "window valid bits have a gap")
	// a completely full row only exists while its head byte is being sent
	`MBSF_ASSERT_IMP(a_full_busy, clk, arst_n, win_valid[mbsf_pkg::MAX_PAT-1], seq_stat.busy, "full window while sequencer idle")
	// the sequencer only starts work on an item it has just taken
	`MBSF_ASSERT_IMP(a_busy_take, clk, arst_n, $rose(seq_stat.busy), $past(seq_stat.take), "sequencer busy without a take")

endmodule
